// File: rtl/pps_pkg.sv
// ----------------------------------------------------------------------------
// pps_pkg
// Shared types and constants of the preemptive priority scheduler: the
// input and result items, the per-slot record kept in the slot memory,
// the operation codes and the control states.
// ----------------------------------------------------------------------------
package pps_pkg;

  // Table geometry
  localparam int SLOTS  = 16;
  localparam int SLOT_W = $clog2(SLOTS);
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int CFG_W  = 5;

  // Field widths
  localparam int TIME_W = 24;
  localparam int DUR_W  = 16;
  localparam int PRI_W  = 8;

  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_TICK = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    op_e               operation;
    logic [3:0]        slot;
    logic [DUR_W-1:0]  arrival_time;
    logic [DUR_W-1:0]  burst_time;
    logic [PRI_W-1:0]  priority_req;
  } item_t;

  typedef struct packed {
    logic [TIME_W-1:0] current_time;
    logic              busy_res;
    logic [3:0]        running_slot;
    logic              finished;
    logic [TIME_W-1:0] completion_time;
    logic [TIME_W-1:0] turnaround_time;
    logic [TIME_W-1:0] waiting_time;
    logic              all_done;
  } res_t;

  // One slot as kept in the slot memory
  typedef struct packed {
    logic [DUR_W-1:0] arrival;
    logic [DUR_W-1:0] burst;
    logic [PRI_W-1:0] prio;
    logic [DUR_W-1:0] remaining;
  } rec_t;

  localparam int REC_W = $bits(rec_t);

endpackage

// File: rtl/pps_ram.sv
// ----------------------------------------------------------------------------
// pps_ram
// Generic single-write, single-read synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module pps_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// File: rtl/preemptive_priority_scheduler_core.sv
// ----------------------------------------------------------------------------
// preemptive_priority_scheduler_core
// Slot table scheduler: loads write a slot record, ticks scan the slot
// memory for the best eligible slot and run it for one time unit.
//
//   channel   signals                          direction  handshake
//   item      start, busy, item_i              in         start && !busy
//   result    valid_o, res_o                   out        one-cycle strobe
//   config    cfg_valid_i, cfg_ready_o, data   in         valid && ready
//
// A load writes the record into the slot memory at the accept edge.
// A tick scans the slots in use, one memory read per slot through the single
// read port; after the last registered read returns, an update cycle writes
// back the chosen slot's remaining time.
// The result strobe follows the update cycle; a new item may start then.
// Reset clears time, done marks and the slot count; records are undefined
// until loaded. Results cannot be stalled.
// ----------------------------------------------------------------------------
module preemptive_priority_scheduler_core
  import pps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  item_t            item_i,
  output logic             valid_o,
  output res_t             res_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [CFG_W-1:0] cfg_data_i
);

  state_e state_q, state_d;

  logic [CFG_W-1:0]  count_q;
  logic [TIME_W-1:0] time_q;
  logic [SLOTS-1:0]  done_q;

  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic              pv_q;
  logic [SLOT_W-1:0] pidx_q;

  logic              found_q;
  logic [SLOT_W-1:0] best_idx_q;
  rec_t              best_q;

  logic              valid_q;
  res_t              res_q;

  logic [CNT_W-1:0]  n_use;
  logic [SLOTS-1:0]  in_use;
  logic              load_acc, tick_acc;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr, ram_raddr;
  rec_t              ram_wdata, ram_rdata;

  logic              elig, better;
  logic [TIME_W-1:0] time_next, tat, wt;
  logic [DUR_W-1:0]  rem_new;
  logic              fin;
  logic [SLOTS-1:0]  done_after;

  assign busy        = (state_q != ST_IDLE);
  assign cfg_ready_o = 1'b1;
  assign valid_o     = valid_q;
  assign res_o       = res_q;

  assign load_acc = start && !busy && (item_i.operation == OP_LOAD) &&
                    (32'(item_i.slot) < SLOTS);
  assign tick_acc = start && !busy && (item_i.operation == OP_TICK);

  // Slots in use, clamped to the table size
  assign n_use = (32'(count_q) > SLOTS) ? CNT_W'(SLOTS) : CNT_W'(count_q);

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      in_use[i] = (i < 32'(n_use));
    end
  end

  // Slot memory
  pps_ram #(
    .WIDTH (REC_W),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign ram_raddr = rd_idx_q[SLOT_W-1:0];

  // Eligibility and ranking of the slot read last cycle
  assign elig   = !done_q[pidx_q] &&
                  ({{(TIME_W-DUR_W){1'b0}}, ram_rdata.arrival} <= time_q);
  assign better = !found_q || (ram_rdata.prio < best_q.prio) ||
                  ((ram_rdata.prio == best_q.prio) &&
                   (ram_rdata.remaining < best_q.remaining));

  // Tick arithmetic for the chosen slot
  assign time_next = (time_q == TIME_MAX) ? time_q : time_q + TIME_W'(1);
  assign rem_new   = (best_q.remaining != '0) ? best_q.remaining - DUR_W'(1) : '0;
  assign fin       = found_q && (rem_new == '0);
  assign tat       = time_next - {{(TIME_W-DUR_W){1'b0}}, best_q.arrival};
  assign wt        = (tat > {{(TIME_W-DUR_W){1'b0}}, best_q.burst}) ?
                     tat - {{(TIME_W-DUR_W){1'b0}}, best_q.burst} : '0;

  always_comb begin
    done_after = done_q;
    if (fin) begin
      done_after[best_idx_q] = 1'b1;
    end
  end

  // Memory write: loads at accept, write-back in the update cycle
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = SLOT_W'(item_i.slot);
    ram_wdata = '{arrival:   item_i.arrival_time,
                  burst:     item_i.burst_time,
                  prio:      item_i.priority_req,
                  remaining: item_i.burst_time};
    if (load_acc) begin
      ram_we = 1'b1;
    end else if (state_q == ST_UPDATE && found_q) begin
      ram_we    = 1'b1;
      ram_waddr = best_idx_q;
      ram_wdata = best_q;
      ram_wdata.remaining = rem_new;
    end
  end

  // Next state and scan address
  always_comb begin
    state_d  = state_q;
    rd_idx_d = rd_idx_q;
    case (state_q)
      ST_IDLE: begin
        rd_idx_d = '0;
        if (tick_acc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (rd_idx_q < n_use) begin
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end else if (!pv_q) begin
          state_d = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      rd_idx_q <= '0;
      pv_q     <= 1'b0;
      count_q  <= '0;
      time_q   <= '0;
      done_q   <= '0;
      found_q  <= 1'b0;
      valid_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      pv_q     <= (state_q == ST_SCAN) && (rd_idx_q < n_use);
      valid_q  <= (state_q == ST_UPDATE);
      if (cfg_valid_i && cfg_ready_o) begin
        count_q <= cfg_data_i;
      end
      if (load_acc) begin
        done_q[SLOT_W'(item_i.slot)] <= 1'b0;
      end
      if (tick_acc) begin
        found_q <= 1'b0;
      end else if (pv_q && elig && better) begin
        found_q <= 1'b1;
      end
      if (state_q == ST_UPDATE) begin
        time_q <= time_next;
        done_q <= done_after;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (state_q == ST_SCAN) begin
      pidx_q <= rd_idx_q[SLOT_W-1:0];
    end
    if (pv_q && elig && better) begin
      best_q     <= ram_rdata;
      best_idx_q <= pidx_q;
    end
    if (state_q == ST_UPDATE) begin
      res_q.current_time    <= time_next;
      res_q.busy_res        <= found_q;
      res_q.running_slot    <= found_q ? 4'(best_idx_q) : '0;
      res_q.finished        <= fin;
      res_q.completion_time <= fin ? time_next : '0;
      res_q.turnaround_time <= fin ? tat : '0;
      res_q.waiting_time    <= fin ? wt : '0;
      res_q.all_done        <= &(done_after | ~in_use);
    end
  end

`ifndef ASSERT_OFF
  // A result only follows an update cycle
  a_res_after_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(state_q == ST_UPDATE))
    else $error("result strobe without update cycle");

  // An idle tick never reports a completion
  a_idle_no_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && !res_o.busy_res) |-> !res_o.finished)
    else $error("completion on idle tick");

  // A completion happens at the reported time
  a_finish_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_o && res_o.finished) |-> (res_o.completion_time == res_o.current_time))
    else $error("completion time mismatch");

  // An accepted tick keeps the block busy next cycle
  a_tick_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tick_acc |=> busy)
    else $error("tick accepted but block not busy");
`endif

endmodule
